[src/pcse_pkg.sv]
// Shared types and codes for the port connection state engine.
package pcse_pkg;

  localparam int LEN_WIDTH = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  typedef logic [LEN_WIDTH-1:0] len_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_TIMEOUT   = 1'd1;

  localparam logic [15:0] CAPACITY_RESET = 16'd4096;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd3000;

  // opcodes
  localparam logic [2:0] OP_PACKET  = 3'd0;
  localparam logic [2:0] OP_CONNECT = 3'd1;
  localparam logic [2:0] OP_CLOSE   = 3'd2;
  localparam logic [2:0] OP_WRITE   = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;
  localparam logic [2:0] OP_TICK    = 3'd5;

  // connection states
  localparam logic [2:0] ST_OPENED    = 3'd0;
  localparam logic [2:0] ST_CONNECTING = 3'd1;
  localparam logic [2:0] ST_CONN_WAIT = 3'd2;
  localparam logic [2:0] ST_CONNECTED = 3'd3;
  localparam logic [2:0] ST_CLOSING   = 3'd4;
  localparam logic [2:0] ST_CLOSED    = 3'd5;
  localparam logic [2:0] ST_LINK_LOST = 3'd6;

  // arriving packet types
  localparam logic [2:0] PK_DATA      = 3'd0;
  localparam logic [2:0] PK_SYNC      = 3'd1;
  localparam logic [2:0] PK_FIN       = 3'd2;
  localparam logic [2:0] PK_ACK_DATA  = 3'd3;
  localparam logic [2:0] PK_ACK_SYNC  = 3'd4;
  localparam logic [2:0] PK_ACK_FIN   = 3'd5;
  localparam logic [2:0] PK_NACK_SYNC = 3'd6;
  localparam logic [2:0] PK_NACK_LINK = 3'd7;

  // outgoing packet types
  localparam logic [2:0] TX_NONE      = 3'd0;
  localparam logic [2:0] TX_SYNC      = 3'd1;
  localparam logic [2:0] TX_FIN       = 3'd2;
  localparam logic [2:0] TX_DATA      = 3'd3;
  localparam logic [2:0] TX_ACK_DATA  = 3'd4;
  localparam logic [2:0] TX_ACK_SYNC  = 3'd5;
  localparam logic [2:0] TX_ACK_FIN   = 3'd6;
  localparam logic [2:0] TX_NACK_SYNC = 3'd7;

  // request completion status
  localparam logic [1:0] RS_OK          = 2'd0;
  localparam logic [1:0] RS_PORT_DISC   = 2'd1;
  localparam logic [1:0] RS_PORT_CLOSED = 2'd2;
  localparam logic [1:0] RS_LINK_DISC   = 2'd3;

  // command status
  localparam logic [2:0] CMD_ACCEPTED    = 3'd0;
  localparam logic [2:0] CMD_BUSY        = 3'd4;
  localparam logic [2:0] CMD_WOULD_BLOCK = 3'd5;

endpackage

[src/port_connection_state_engine_core.sv]
// Port connection state engine: one event per request, one result per request.
//
//   channel | handshake          | payload
//   --------+--------------------+----------------------------------------------
//   in      | in_valid/in_stall  | opcode, pkt_type, length
//   out     | out_valid/out_stall| state_now, send_type, send_length, *_done,
//           |                    | *_status, cmd_status, buffered_bytes, link_reset
//   cfg     | cfg_we             | cfg_index, cfg_data
//
// A request is registered on entry and its result is then registered in the output
// register; one request per cycle is sustained while the result port does not stall,
// as the state update between the two registers is combinational.
// Reset (rst, synchronous) empties both registers and returns all state and
// configuration to defaults. A stalled result holds; the entry register keeps
// taking one request while the result waits.
module port_connection_state_engine_core
  import pcse_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            opcode,
  input  logic [2:0]            pkt_type,
  input  len_t                  length,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            state_now,
  output logic [2:0]            send_type,
  output len_t                  send_length,
  output logic                  sync_done,
  output logic [1:0]            sync_status,
  output logic                  data_done,
  output logic [1:0]            data_status,
  output logic                  fin_done,
  output logic [1:0]            fin_status,
  output logic [2:0]            cmd_status,
  output len_t                  buffered_bytes,
  output logic                  link_reset
);

  logic [15:0] buffer_capacity;
  logic [15:0] close_timeout_ticks;

  // entry register
  logic       q_valid;
  logic [2:0] q_opcode;
  logic [2:0] q_pkt_type;
  len_t       q_length;
  logic       adv;

  // connection state
  logic [2:0] conn_state, conn_state_next;
  logic [1:0] disc_reason, disc_reason_next;
  len_t       rx_count, rx_count_next;
  len_t       write_total, write_total_next;
  len_t       acked_total, acked_total_next;
  logic       sync_pending, sync_pending_next;
  logic       data_pending, data_pending_next;
  logic       fin_pending, fin_pending_next;
  len_t       close_ticks, close_ticks_next;

  // result of the current request
  logic [2:0] r_send_type;
  len_t       r_send_length;
  logic       r_sync_done, r_data_done, r_fin_done;
  logic [1:0] r_sync_status, r_data_status, r_fin_status;
  logic [2:0] r_cmd_status;
  logic       r_link_reset;

  assign adv      = q_valid && (!out_valid || !out_stall);
  assign in_stall = q_valid && !adv;

  always_comb begin
    logic            req_sync, req_data, req_fin;
    logic [1:0]      st_sync, st_data, st_fin;
    logic            lose;
    logic [LEN_WIDTH:0] sum;
    len_t            ticks_inc;
    len_t            rd_n;

    conn_state_next   = conn_state;
    disc_reason_next  = disc_reason;
    rx_count_next     = rx_count;
    write_total_next  = write_total;
    acked_total_next  = acked_total;
    sync_pending_next = sync_pending;
    data_pending_next = data_pending;
    fin_pending_next  = fin_pending;
    close_ticks_next  = close_ticks;

    r_send_type   = TX_NONE;
    r_send_length = '0;
    r_sync_done   = 1'b0;
    r_sync_status = RS_OK;
    r_data_done   = 1'b0;
    r_data_status = RS_OK;
    r_fin_done    = 1'b0;
    r_fin_status  = RS_OK;
    r_cmd_status  = CMD_ACCEPTED;
    r_link_reset  = 1'b0;

    req_sync = 1'b0;
    req_data = 1'b0;
    req_fin  = 1'b0;
    st_sync  = RS_OK;
    st_data  = RS_OK;
    st_fin   = RS_OK;
    lose     = 1'b0;
    sum      = '0;
    ticks_inc = '0;
    rd_n     = '0;

    unique case (q_opcode)
      OP_PACKET: begin
        close_ticks_next = '0;
        unique case (conn_state)
          ST_OPENED, ST_CLOSED: begin
            priority if (q_pkt_type == PK_SYNC) begin
              r_send_type = TX_NACK_SYNC;
            end else if (q_pkt_type == PK_FIN) begin
              r_send_type = TX_ACK_FIN;
            end else if (q_pkt_type == PK_NACK_LINK && conn_state == ST_OPENED) begin
              lose = 1'b1;
            end else begin
            end
          end
          ST_CONNECTING, ST_CONN_WAIT: begin
            priority if (q_pkt_type == PK_NACK_SYNC && conn_state == ST_CONNECTING) begin
              conn_state_next = ST_CONN_WAIT;
            end else if (q_pkt_type == PK_SYNC) begin
              r_send_type = TX_ACK_SYNC;
              if (conn_state == ST_CONN_WAIT) begin
                req_sync        = 1'b1;
                conn_state_next = ST_CONNECTED;
              end
            end else if (q_pkt_type == PK_ACK_SYNC && conn_state == ST_CONNECTING) begin
              req_sync        = 1'b1;
              conn_state_next = ST_CONNECTED;
            end else if (q_pkt_type == PK_FIN) begin
              r_send_type     = TX_ACK_FIN;
              conn_state_next = ST_CONN_WAIT;
            end else if (q_pkt_type == PK_NACK_LINK) begin
              lose = 1'b1;
            end else begin
            end
          end
          ST_CONNECTED, ST_CLOSING: begin
            priority if (q_pkt_type == PK_DATA) begin
              // receive count saturates at capacity, excess is dropped
              if (rx_count < buffer_capacity) begin
                sum = {1'b0, rx_count} + {1'b0, q_length};
                rx_count_next = (sum > {1'b0, buffer_capacity}) ? buffer_capacity
                                                                : sum[LEN_WIDTH-1:0];
              end
            end else if (q_pkt_type == PK_ACK_DATA) begin
              if (data_pending) begin
                sum = {1'b0, acked_total} + {1'b0, q_length};
                acked_total_next = sum[LEN_WIDTH] ? '1 : sum[LEN_WIDTH-1:0];
                if (acked_total_next == write_total) req_data = 1'b1;
              end
            end else if (q_pkt_type == PK_FIN) begin
              r_send_type = TX_ACK_FIN;
              if (conn_state == ST_CONNECTED) begin
                rx_count_next   = '0;
                req_data        = 1'b1;
                st_data         = disc_reason;
                conn_state_next = ST_CLOSED;
              end
            end else if (q_pkt_type == PK_ACK_FIN && conn_state == ST_CLOSING) begin
              rx_count_next   = '0;
              req_sync        = 1'b1;
              st_sync         = disc_reason;
              req_data        = 1'b1;
              st_data         = disc_reason;
              req_fin         = 1'b1;
              conn_state_next = ST_CLOSED;
            end else if (q_pkt_type == PK_NACK_LINK) begin
              lose = 1'b1;
            end else begin
            end
          end
          default: begin
          end
        endcase
      end
      OP_CONNECT: begin
        if (conn_state == ST_OPENED) begin
          conn_state_next   = ST_CONNECTING;
          sync_pending_next = 1'b1;
          r_send_type       = TX_SYNC;
        end else begin
          r_cmd_status = (conn_state == ST_LINK_LOST) ? {1'b0, RS_LINK_DISC} : CMD_BUSY;
        end
      end
      OP_CLOSE: begin
        disc_reason_next = RS_PORT_CLOSED;
        if (conn_state == ST_OPENED || conn_state == ST_CLOSED ||
            conn_state == ST_LINK_LOST) begin
          conn_state_next = ST_CLOSED;
        end else begin
          if (conn_state != ST_CLOSING) begin
            r_send_type      = TX_FIN;
            fin_pending_next = 1'b1;
          end
          conn_state_next  = ST_CLOSING;
          close_ticks_next = '0;
        end
      end
      OP_WRITE: begin
        priority if (conn_state != ST_CONNECTED) begin
          r_cmd_status = {1'b0, disc_reason};
        end else if (data_pending) begin
          r_cmd_status = CMD_BUSY;
        end else begin
          write_total_next  = q_length;
          acked_total_next  = '0;
          data_pending_next = 1'b1;
          r_send_type       = TX_DATA;
          r_send_length     = q_length;
        end
      end
      OP_READ: begin
        rd_n = (q_length < rx_count) ? q_length : rx_count;
        priority if (conn_state != ST_CONNECTED) begin
          r_cmd_status = {1'b0, disc_reason};
        end else if (rd_n == '0) begin
          r_cmd_status = CMD_WOULD_BLOCK;
        end else begin
          rx_count_next = rx_count - rd_n;
          r_send_type   = TX_ACK_DATA;
          r_send_length = rd_n;
        end
      end
      OP_TICK: begin
        if (conn_state == ST_CLOSING) begin
          ticks_inc = (close_ticks != '1) ? close_ticks + 1'b1 : close_ticks;
          if (ticks_inc >= close_timeout_ticks) begin
            r_link_reset     = 1'b1;
            disc_reason_next = RS_LINK_DISC;
            rx_count_next    = '0;
            req_sync         = 1'b1;
            st_sync          = RS_LINK_DISC;
            req_data         = 1'b1;
            st_data          = RS_LINK_DISC;
            req_fin          = 1'b1;
            st_fin           = RS_LINK_DISC;
            conn_state_next  = ST_CLOSED;
            close_ticks_next = '0;
          end else begin
            close_ticks_next = ticks_inc;
          end
        end
      end
      default: begin
      end
    endcase

    if (lose) begin
      disc_reason_next = RS_LINK_DISC;
      rx_count_next    = '0;
      req_sync         = 1'b1;
      st_sync          = RS_LINK_DISC;
      req_data         = 1'b1;
      st_data          = RS_LINK_DISC;
      req_fin          = 1'b1;
      st_fin           = RS_LINK_DISC;
      conn_state_next  = ST_LINK_LOST;
    end

    // completions only fire for requests that are outstanding
    if (req_sync && sync_pending) begin
      sync_pending_next = 1'b0;
      r_sync_done       = 1'b1;
      r_sync_status     = st_sync;
    end
    if (req_data && data_pending) begin
      data_pending_next = 1'b0;
      r_data_done       = 1'b1;
      r_data_status     = st_data;
    end
    if (req_fin && fin_pending) begin
      fin_pending_next = 1'b0;
      r_fin_done       = 1'b1;
      r_fin_status     = st_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_capacity     <= CAPACITY_RESET;
      close_timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BUFFER_CAPACITY: buffer_capacity     <= cfg_data;
        CFG_CLOSE_TIMEOUT:   close_timeout_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      q_valid <= 1'b1;
    end else if (adv) begin
      q_valid <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      q_opcode   <= opcode;
      q_pkt_type <= pkt_type;
      q_length   <= length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      conn_state   <= ST_OPENED;
      disc_reason  <= RS_PORT_DISC;
      rx_count     <= '0;
      write_total  <= '0;
      acked_total  <= '0;
      sync_pending <= 1'b0;
      data_pending <= 1'b0;
      fin_pending  <= 1'b0;
      close_ticks  <= '0;
    end else if (adv) begin
      conn_state   <= conn_state_next;
      disc_reason  <= disc_reason_next;
      rx_count     <= rx_count_next;
      write_total  <= write_total_next;
      acked_total  <= acked_total_next;
      sync_pending <= sync_pending_next;
      data_pending <= data_pending_next;
      fin_pending  <= fin_pending_next;
      close_ticks  <= close_ticks_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (adv) begin
      state_now      <= conn_state_next;
      send_type      <= r_send_type;
      send_length    <= r_send_length;
      sync_done      <= r_sync_done;
      sync_status    <= r_sync_status;
      data_done      <= r_data_done;
      data_status    <= r_data_status;
      fin_done       <= r_fin_done;
      fin_status     <= r_fin_status;
      cmd_status     <= r_cmd_status;
      buffered_bytes <= rx_count_next;
      link_reset     <= r_link_reset;
    end
  end

endmodule

[src/pcse_checker.sv]
// Port-level checks for the port connection state engine, bound to the top level.
module pcse_checker
  import pcse_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [2:0]            state_now,
  input logic [2:0]            send_type,
  input len_t                  send_length,
  input logic                  sync_done,
  input logic [1:0]            sync_status,
  input logic                  data_done,
  input logic [1:0]            data_status,
  input logic                  fin_done,
  input logic [1:0]            fin_status,
  input len_t                  buffered_bytes,
  input logic                  link_reset
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(send_type) &&
      $stable(send_length) && $stable(buffered_bytes))
    else $error("stalled result changed");

  // a timed-out close ends closed with an empty receive buffer
  a_link_reset: assert property (@(posedge clk) disable iff (rst)
    out_valid && link_reset |-> state_now == ST_CLOSED && buffered_bytes == '0)
    else $error("link reset without closed state and empty buffer");

  // status fields are zero unless their completion fires
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sync_done || sync_status == RS_OK) &&
      (data_done || data_status == RS_OK) && (fin_done || fin_status == RS_OK))
    else $error("status reported without completion");

  // a link-lost result has an empty buffer; any sync or fin completion reports link disconnected
  a_link_lost: assert property (@(posedge clk) disable iff (rst)
    out_valid && state_now == ST_LINK_LOST |-> buffered_bytes == '0 &&
      (!sync_done || sync_status == RS_LINK_DISC) &&
      (!fin_done || fin_status == RS_LINK_DISC))
    else $error("link lost with inconsistent completion");

endmodule

bind port_connection_state_engine_core pcse_checker u_pcse_checker (.*);

[dv/tb.sv]
// Testbench for the port connection state engine: scoreboard, drivers and checks.
`timescale 1ns / 100ps

module tb;
  import pcse_pkg::*;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [2:0] state_now;
    logic [2:0] send_type;
    len_t       send_length;
    logic       sync_done;
    logic [1:0] sync_status;
    logic       data_done;
    logic [1:0] data_status;
    logic       fin_done;
    logic [1:0] fin_status;
    logic [2:0] cmd_status;
    len_t       buffered_bytes;
    logic       link_reset;
  } outcome_t;

  // Tracks the connection the way the engine should and keeps the outcomes still owed.
  class port_state_tracker;
    logic [15:0] capacity;
    logic [15:0] timeout;
    logic [2:0]  state;
    logic [1:0]  reason;
    len_t        rx_count;
    len_t        write_total;
    len_t        acked_total;
    bit          sync_pend;
    bit          data_pend;
    bit          fin_pend;
    len_t        close_ticks;
    outcome_t    cur;
    outcome_t    outcome_q[$];
    int          failures;

    function new();
      capacity    = CAPACITY_RESET;
      timeout     = TIMEOUT_RESET;
      state       = ST_OPENED;
      reason      = RS_PORT_DISC;
      rx_count    = '0;
      write_total = '0;
      acked_total = '0;
      sync_pend   = 1'b0;
      data_pend   = 1'b0;
      fin_pend    = 1'b0;
      close_ticks = '0;
      failures    = 0;
    endfunction

    function void finish_sync(logic [1:0] st);
      if (sync_pend) begin
        sync_pend = 1'b0;
        cur.sync_done = 1'b1;
        cur.sync_status = st;
      end
    endfunction

    function void finish_data(logic [1:0] st);
      if (data_pend) begin
        data_pend = 1'b0;
        cur.data_done = 1'b1;
        cur.data_status = st;
      end
    endfunction

    function void finish_fin(logic [1:0] st);
      if (fin_pend) begin
        fin_pend = 1'b0;
        cur.fin_done = 1'b1;
        cur.fin_status = st;
      end
    endfunction

    function void drop_link();
      reason = RS_LINK_DISC;
      rx_count = '0;
      finish_sync(RS_LINK_DISC);
      finish_data(RS_LINK_DISC);
      finish_fin(RS_LINK_DISC);
      state = ST_LINK_LOST;
    endfunction

    function void on_packet(logic [2:0] ptype, len_t len);
      logic [16:0] sum;
      close_ticks = '0;
      case (state)
        ST_OPENED, ST_CLOSED: begin
          if (ptype == PK_SYNC) cur.send_type = TX_NACK_SYNC;
          else if (ptype == PK_FIN) cur.send_type = TX_ACK_FIN;
          else if (ptype == PK_NACK_LINK && state == ST_OPENED) drop_link();
        end
        ST_CONNECTING, ST_CONN_WAIT: begin
          if (ptype == PK_NACK_SYNC && state == ST_CONNECTING) begin
            state = ST_CONN_WAIT;
          end else if (ptype == PK_SYNC) begin
            cur.send_type = TX_ACK_SYNC;
            if (state == ST_CONN_WAIT) begin
              finish_sync(RS_OK);
              state = ST_CONNECTED;
            end
          end else if (ptype == PK_ACK_SYNC && state == ST_CONNECTING) begin
            finish_sync(RS_OK);
            state = ST_CONNECTED;
          end else if (ptype == PK_FIN) begin
            cur.send_type = TX_ACK_FIN;
            state = ST_CONN_WAIT;
          end else if (ptype == PK_NACK_LINK) begin
            drop_link();
          end
        end
        ST_CONNECTED, ST_CLOSING: begin
          if (ptype == PK_DATA) begin
            // nothing is taken once the count has reached capacity
            if (rx_count < capacity) begin
              sum = {1'b0, rx_count} + {1'b0, len};
              rx_count = (sum > {1'b0, capacity}) ? capacity : sum[15:0];
            end
          end else if (ptype == PK_ACK_DATA) begin
            if (data_pend) begin
              sum = {1'b0, acked_total} + {1'b0, len};
              acked_total = sum[16] ? 16'hFFFF : sum[15:0];
              if (acked_total == write_total) finish_data(RS_OK);
            end
          end else if (ptype == PK_FIN) begin
            cur.send_type = TX_ACK_FIN;
            if (state == ST_CONNECTED) begin
              rx_count = '0;
              finish_data(reason);
              state = ST_CLOSED;
            end
          end else if (ptype == PK_ACK_FIN && state == ST_CLOSING) begin
            rx_count = '0;
            finish_sync(reason);
            finish_data(reason);
            finish_fin(RS_OK);
            state = ST_CLOSED;
          end else if (ptype == PK_NACK_LINK) begin
            drop_link();
          end
        end
        default: ;
      endcase
    endfunction

    function void note_event(logic [2:0] op, logic [2:0] ptype, len_t len);
      len_t n;
      cur = '0;
      case (op)
        OP_PACKET: on_packet(ptype, len);
        OP_CONNECT: begin
          if (state == ST_OPENED) begin
            state = ST_CONNECTING;
            sync_pend = 1'b1;
            cur.send_type = TX_SYNC;
          end else begin
            cur.cmd_status = (state == ST_LINK_LOST) ? {1'b0, RS_LINK_DISC} : CMD_BUSY;
          end
        end
        OP_CLOSE: begin
          reason = RS_PORT_CLOSED;
          if (state == ST_OPENED || state == ST_CLOSED || state == ST_LINK_LOST) begin
            state = ST_CLOSED;
          end else begin
            if (state != ST_CLOSING) begin
              cur.send_type = TX_FIN;
              fin_pend = 1'b1;
            end
            state = ST_CLOSING;
            close_ticks = '0;
          end
        end
        OP_WRITE: begin
          if (state != ST_CONNECTED) begin
            cur.cmd_status = {1'b0, reason};
          end else if (data_pend) begin
            cur.cmd_status = CMD_BUSY;
          end else begin
            write_total = len;
            acked_total = '0;
            data_pend = 1'b1;
            cur.send_type = TX_DATA;
            cur.send_length = len;
          end
        end
        OP_READ: begin
          if (state != ST_CONNECTED) begin
            cur.cmd_status = {1'b0, reason};
          end else begin
            n = (len < rx_count) ? len : rx_count;
            if (n == 0) begin
              cur.cmd_status = CMD_WOULD_BLOCK;
            end else begin
              rx_count = rx_count - n;
              cur.send_type = TX_ACK_DATA;
              cur.send_length = n;
            end
          end
        end
        OP_TICK: begin
          if (state == ST_CLOSING) begin
            if (close_ticks != 16'hFFFF) close_ticks = close_ticks + 1'b1;
            if (close_ticks >= timeout) begin
              cur.link_reset = 1'b1;
              reason = RS_LINK_DISC;
              rx_count = '0;
              finish_sync(RS_LINK_DISC);
              finish_data(RS_LINK_DISC);
              finish_fin(RS_LINK_DISC);
              state = ST_CLOSED;
              close_ticks = '0;
            end
          end
        end
        default: ;
      endcase
      cur.state_now = state;
      cur.buffered_bytes = rx_count;
      outcome_q.push_back(cur);
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("ERROR at %0t: %s", $time, msg);
    endfunction

    function void check_outcome(outcome_t got);
      outcome_t want;
      string bad;
      if (outcome_q.size() == 0) begin
        flag($sformatf("result with nothing outstanding: %p", got));
        return;
      end
      want = outcome_q.pop_front();
      bad = "";
      if (got.state_now !== want.state_now) bad = {bad, " state_now"};
      if (got.send_type !== want.send_type) bad = {bad, " send_type"};
      if (got.send_length !== want.send_length) bad = {bad, " send_length"};
      if (got.sync_done !== want.sync_done) bad = {bad, " sync_done"};
      if (got.sync_status !== want.sync_status) bad = {bad, " sync_status"};
      if (got.data_done !== want.data_done) bad = {bad, " data_done"};
      if (got.data_status !== want.data_status) bad = {bad, " data_status"};
      if (got.fin_done !== want.fin_done) bad = {bad, " fin_done"};
      if (got.fin_status !== want.fin_status) bad = {bad, " fin_status"};
      if (got.cmd_status !== want.cmd_status) bad = {bad, " cmd_status"};
      if (got.buffered_bytes !== want.buffered_bytes) bad = {bad, " buffered_bytes"};
      if (got.link_reset !== want.link_reset) bad = {bad, " link_reset"};
      if (bad != "") flag($sformatf("mismatch on%s: expected %p, got %p", bad, want, got));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [2:0]            opcode = '0;
  logic [2:0]            pkt_type = '0;
  len_t                  length = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [2:0]            state_now;
  logic [2:0]            send_type;
  len_t                  send_length;
  logic                  sync_done;
  logic [1:0]            sync_status;
  logic                  data_done;
  logic [1:0]            data_status;
  logic                  fin_done;
  logic [1:0]            fin_status;
  logic [2:0]            cmd_status;
  len_t                  buffered_bytes;
  logic                  link_reset;

  port_state_tracker tracker = new();
  bit tx_gaps_on = 1'b1;
  bit rx_gaps_on = 1'b1;
  bit burst_mode = 1'b0;
  int hold_request = 0;
  int cycle_count = 0;

  port_connection_state_engine_core dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.check_outcome({state_now, send_type, send_length, sync_done, sync_status,
                             data_done, data_status, fin_done, fin_status, cmd_status,
                             buffered_bytes, link_reset});
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : receiver
    int wait_n;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        out_stall <= 1'b1;
        for (int c = 0; c < hold_request; c++) @(posedge clk);
        hold_request = 0;
      end else begin
        if ($urandom_range(0, 39) == 0) rx_gaps_on = !rx_gaps_on;
        wait_n = rx_gaps_on ? $urandom_range(0, 10) : 0;
        if (wait_n > 0) begin
          out_stall <= 1'b1;
          repeat (wait_n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid && hold_request == 0) @(posedge clk);
    end
  end

  function automatic len_t pick_len();
    case ($urandom_range(0, 15))
      0: return len_t'($urandom);
      1: return '0;
      2: return 16'hFFFF;
      3: return len_t'($urandom_range(0, 4096));
      default: return len_t'($urandom_range(1, 64));
    endcase
  endfunction

  task automatic offer_event(logic [2:0] op, logic [2:0] ptype, len_t len);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_gaps_on = !tx_gaps_on;
    gap = (tx_gaps_on && !burst_mode) ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    pkt_type <= ptype;
    length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_event(op, ptype, len);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.outcome_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_limits(logic [15:0] cap, logic [15:0] tmo);
    cfg_we <= 1'b1;
    cfg_index <= CFG_BUFFER_CAPACITY;
    cfg_data <= cap;
    @(posedge clk);
    cfg_index <= CFG_CLOSE_TIMEOUT;
    cfg_data <= tmo;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.capacity = cap;
    tracker.timeout = tmo;
  endtask

  // Mostly well-formed traffic for an open connection: writes answered by acks that
  // add up to the write length, arriving data and reads; no close, FIN or link loss.
  task automatic connected_event();
    int r;
    len_t rem;
    logic [2:0] junk;
    r = $urandom_range(0, 99);
    junk = 3'($urandom);
    if (r < 20) begin
      offer_event(OP_PACKET, PK_DATA, pick_len());
    end else if (r < 40) begin
      if (tracker.data_pend) begin
        rem = tracker.write_total - tracker.acked_total;
        offer_event(OP_PACKET, PK_ACK_DATA,
                    $urandom_range(0, 1) ? rem : len_t'($urandom_range(0, rem)));
      end else begin
        offer_event(OP_WRITE, junk, pick_len());
      end
    end else if (r < 55) begin
      offer_event(OP_WRITE, junk, pick_len());
    end else if (r < 72) begin
      offer_event(OP_READ, junk, pick_len());
    end else if (r < 78) begin
      if (!tracker.data_pend) offer_event(OP_PACKET, PK_ACK_DATA, pick_len());
      else offer_event(OP_TICK, junk, pick_len());
    end else if (r < 86) begin
      offer_event(OP_TICK, junk, pick_len());
    end else if (r < 91) begin
      offer_event(OP_CONNECT, junk, pick_len());
    end else if (r < 97) begin
      case ($urandom_range(0, 3))
        0: offer_event(OP_PACKET, PK_SYNC, pick_len());
        1: offer_event(OP_PACKET, PK_ACK_SYNC, pick_len());
        2: offer_event(OP_PACKET, PK_NACK_SYNC, pick_len());
        default: offer_event(OP_PACKET, PK_ACK_FIN, pick_len());
      endcase
    end else begin
      offer_event($urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7, junk, pick_len());
    end
  endtask

  task automatic closing_event();
    int r;
    logic [2:0] junk;
    r = $urandom_range(0, 99);
    junk = 3'($urandom);
    if (r < 35) offer_event(OP_TICK, junk, pick_len());
    else if (r < 50) offer_event(OP_PACKET, PK_DATA, pick_len());
    else if (r < 65) offer_event(OP_PACKET, PK_ACK_DATA, pick_len());
    else if (r < 70) offer_event(OP_CLOSE, junk, pick_len());
    else if (r < 74) offer_event(OP_READ, junk, pick_len());
    else if (r < 78) offer_event(OP_WRITE, junk, pick_len());
    else if (r < 81) offer_event(OP_CONNECT, junk, pick_len());
    else if (r < 95) begin
      case ($urandom_range(0, 3))
        0: offer_event(OP_PACKET, PK_SYNC, pick_len());
        1: offer_event(OP_PACKET, PK_FIN, pick_len());
        2: offer_event(OP_PACKET, PK_ACK_SYNC, pick_len());
        default: offer_event(OP_PACKET, PK_NACK_SYNC, pick_len());
      endcase
    end
    else if (r < 97) offer_event(OP_PACKET, PK_ACK_FIN, pick_len());
    else offer_event(OP_PACKET, PK_NACK_LINK, pick_len());
  endtask

  initial begin : stimulus
    logic [15:0] tmo;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // opened: spare opcodes, commands before connecting, stray packets
    offer_event(OP_SPARE6, PK_NACK_LINK, 16'hFFFF);
    offer_event(OP_SPARE7, PK_DATA, 16'h0000);
    offer_event(OP_READ, PK_DATA, 16'd10);
    offer_event(OP_WRITE, PK_DATA, 16'd5);
    offer_event(OP_TICK, PK_DATA, 16'd0);
    offer_event(OP_PACKET, PK_SYNC, 16'd0);
    offer_event(OP_PACKET, PK_FIN, 16'd0);
    offer_event(OP_PACKET, PK_ACK_DATA, 16'd7);
    offer_event(OP_PACKET, PK_DATA, 16'd100);
    // handshake through the wait state
    offer_event(OP_CONNECT, PK_DATA, 16'd0);
    offer_event(OP_CONNECT, PK_DATA, 16'd0);
    offer_event(OP_WRITE, PK_DATA, 16'd4);
    offer_event(OP_PACKET, PK_NACK_SYNC, 16'd0);
    offer_event(OP_PACKET, PK_FIN, 16'd0);
    offer_event(OP_PACKET, PK_SYNC, 16'd0);
    // connected: empty read, stray ack, busy write, saturating acks, zero-length write
    offer_event(OP_READ, PK_DATA, 16'd5);
    offer_event(OP_PACKET, PK_ACK_DATA, 16'd9);
    offer_event(OP_WRITE, PK_DATA, 16'hFFFF);
    offer_event(OP_WRITE, PK_DATA, 16'd1);
    offer_event(OP_PACKET, PK_ACK_DATA, 16'd60000);
    offer_event(OP_PACKET, PK_ACK_DATA, 16'd60000);
    offer_event(OP_WRITE, PK_DATA, 16'd0);
    offer_event(OP_PACKET, PK_ACK_DATA, 16'd0);
    offer_event(OP_PACKET, PK_DATA, 16'hFFFF);
    offer_event(OP_READ, PK_DATA, 16'd0);
    offer_event(OP_READ, PK_DATA, 16'd100);
    // capacity dropped below the buffered count: new data is discarded
    drain();
    set_limits(16'd1, 16'hFFFF);
    offer_event(OP_PACKET, PK_DATA, 16'd10);
    offer_event(OP_READ, PK_DATA, 16'hFFFF);

    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 1) begin
        drain();
        set_limits(16'hFFFF, 16'd1);
      end else if (ph == 2) begin
        drain();
        set_limits(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
        // back-to-back requests against a held-off result port
        burst_mode = 1'b1;
        hold_request = 100;
      end else if (ph == 3) begin
        drain();
        set_limits(16'($urandom_range(16, 512)), TIMEOUT_RESET);
      end
      for (int n = 0; n < 190; n++) begin
        if (n == 40) burst_mode = 1'b0;
        connected_event();
      end
    end

    // leave the connection one of three ways
    drain();
    tmo = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 8));
    set_limits(16'($urandom_range(1, 65535)), tmo);
    if (!tracker.data_pend) offer_event(OP_WRITE, PK_DATA, 16'd50);
    case ($urandom_range(0, 5))
      0: offer_event(OP_PACKET, PK_FIN, pick_len());
      1: offer_event(OP_PACKET, PK_NACK_LINK, pick_len());
      default: begin
        offer_event(OP_CLOSE, PK_DATA, 16'd0);
        for (int n = 0; n < 150 && tracker.state == ST_CLOSING; n++) closing_event();
      end
    endcase

    // closed or link lost: anything goes
    for (int n = 0; n < 200; n++)
      offer_event(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), pick_len());

    drain();
    repeat (10) @(posedge clk);
    if (tracker.failures == 0 && tracker.outcome_q.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
